// ===== rtl/mse_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mse_pkg: shared types and constants of the merge sort engine
// Holds the queue item format between the front and back parts, the result
// format and the state encoding of the sort sequencer.
// ----------------------------------------------------------------------------
package mse_pkg;

	localparam int unsigned DATA_W  = 32;
	localparam int unsigned Q_DEPTH = 4;
	localparam int unsigned Q_AW    = 2;

	// one classified request, as the front part hands it to the back part
	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     last;
		logic                     keep;   // fits in the store
		logic                     ovf;    // some request of this list was dropped
	} mse_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     last;
		logic                     ovf;
	} mse_result_t;

	typedef enum logic [2:0] {
		B_LOAD,
		B_SETUP,
		B_RD,
		B_MRG,
		B_EMIT_RD,
		B_EMIT_OUT
	} mse_bstate_t;

endpackage
`default_nettype wire

// ===== rtl/mse_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mse_front: request intake and classification
// Counts the requests of the current list, marks each as kept or dropped and
// tracks the overflow flag of the list.
// ----------------------------------------------------------------------------
module mse_front #(
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   in_valid,
	input  wire logic signed [mse_pkg::DATA_W-1:0]      in_value,
	input  wire logic                                   in_last,
	input  wire logic                                   q_full,
	output logic                                        in_ready,
	output logic                                        push,
	output mse_pkg::mse_item_t                          push_item
);

	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [CW-1:0] cnt_q;
	logic          drop_q;
	logic          keep;

	assign in_ready = ~q_full;
	assign push     = in_valid & in_ready;
	assign keep     = (cnt_q < CW'(DEPTH));

	always_comb begin
		push_item.value = in_value;
		push_item.last  = in_last;
		push_item.keep  = keep;
		push_item.ovf   = drop_q | ~keep;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			drop_q <= 1'b0;
		end else if (push) begin
			if (in_last) begin
				cnt_q  <= '0;
				drop_q <= 1'b0;
			end else begin
				if (keep) begin
					cnt_q <= cnt_q + 1'b1;
				end
				drop_q <= drop_q | ~keep;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/mse_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mse_fifo: short request queue
// Decouples intake from the sort sequencer so each side can stall alone.
// ----------------------------------------------------------------------------
module mse_fifo (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire mse_pkg::mse_item_t  push_item,
	input  wire logic                pop,
	output mse_pkg::mse_item_t       pop_item,
	output logic                     full,
	output logic                     empty
);

	mse_pkg::mse_item_t            entry_q [mse_pkg::Q_DEPTH];
	logic [mse_pkg::Q_AW-1:0]      wr_ptr_q;
	logic [mse_pkg::Q_AW-1:0]      rd_ptr_q;
	logic [mse_pkg::Q_AW:0]        cnt_q;
	logic                          do_pop;

	assign full     = (cnt_q == (mse_pkg::Q_AW + 1)'(mse_pkg::Q_DEPTH));
	assign empty    = (cnt_q == '0);
	assign do_pop   = pop & ~empty;
	assign pop_item = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/mse_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mse_back: load, bottom-up merge and emit
// Writes kept elements into store A, merges runs of doubling width between
// stores A and B (each element is read in B_RD, then compared and written
// in B_MRG), then reads the sorted store out through a result register.
// ----------------------------------------------------------------------------
module mse_back #(
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                q_empty,
	input  wire mse_pkg::mse_item_t  q_item,
	output logic                     q_pop,
	input  wire logic                out_ready,
	output logic                     out_valid,
	output mse_pkg::mse_result_t     out_res
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned XW = CW + 2;

	mse_pkg::mse_bstate_t state_q, state_nxt;

	logic signed [mse_pkg::DATA_W-1:0] mem_a [DEPTH];
	logic signed [mse_pkg::DATA_W-1:0] mem_b [DEPTH];
	logic signed [mse_pkg::DATA_W-1:0] ax_q, ay_q, bx_q, by_q;

	logic [CW-1:0] wcnt_q, n_q, lo_q, mid_q, hi_q, i_q, j_q, k_q, e_q;
	logic [XW-1:0] w_q;
	logic          sel_q;
	logic          ovf_q;
	logic          out_valid_q;
	mse_pkg::mse_result_t res_q;

	logic signed [mse_pkg::DATA_W-1:0] x, y, merge_val, wd_a;
	logic          take_x, run_end, pass_end, sort_done, out_free, emit_last;
	logic [CW-1:0] n_new, k_inc, mid_nxt, hi_nxt;
	logic [XW-1:0] lo_w, lo_2w, n_x, w2;
	logic [AW-1:0] addr_x, addr_y, wa_a;
	logic          we_a, we_b;
	logic          emitting;

	assign x         = sel_q ? bx_q : ax_q;
	assign y         = sel_q ? by_q : ay_q;
	assign take_x    = (i_q < mid_q) && ((j_q >= hi_q) || (x <= y));
	assign merge_val = take_x ? x : y;

	assign n_x     = XW'(n_q);
	assign lo_w    = XW'(lo_q) + w_q;
	assign w2      = w_q << 1;
	assign lo_2w   = XW'(lo_q) + w2;
	assign mid_nxt = (lo_w > n_x) ? n_q : lo_w[CW-1:0];
	assign hi_nxt  = (lo_2w > n_x) ? n_q : lo_2w[CW-1:0];

	assign k_inc     = k_q + 1'b1;
	assign run_end   = (k_inc == hi_q);
	assign pass_end  = run_end && (hi_q == n_q);
	assign sort_done = (w2 >= n_x);

	assign out_free  = ~out_valid_q | out_ready;
	assign emit_last = ((e_q + 1'b1) == n_q);

	assign q_pop    = (state_q == mse_pkg::B_LOAD) && !q_empty;
	assign n_new    = wcnt_q + CW'(q_item.keep);
	assign emitting = (state_q == mse_pkg::B_EMIT_RD) || (state_q == mse_pkg::B_EMIT_OUT);

	assign addr_x = emitting ? e_q[AW-1:0] : i_q[AW-1:0];
	assign addr_y = j_q[AW-1:0];

	assign we_a = (q_pop && q_item.keep) || ((state_q == mse_pkg::B_MRG) && sel_q);
	assign wa_a = q_pop ? wcnt_q[AW-1:0] : k_q[AW-1:0];
	assign wd_a = q_pop ? q_item.value : merge_val;
	assign we_b = (state_q == mse_pkg::B_MRG) && !sel_q;

	assign out_valid = out_valid_q;
	assign out_res   = res_q;

	// stores: one write and two registered reads each
	always_ff @(posedge clk) begin
		if (we_a) begin
			mem_a[wa_a] <= wd_a;
		end
		if (we_b) begin
			mem_b[k_q[AW-1:0]] <= merge_val;
		end
		ax_q <= mem_a[addr_x];
		ay_q <= mem_a[addr_y];
		bx_q <= mem_b[addr_x];
		by_q <= mem_b[addr_y];
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			mse_pkg::B_LOAD: begin
				if (q_pop && q_item.last) begin
					if (n_new == '0) begin
						state_nxt = mse_pkg::B_LOAD;
					end else if (n_new == CW'(1)) begin
						state_nxt = mse_pkg::B_EMIT_RD;
					end else begin
						state_nxt = mse_pkg::B_SETUP;
					end
				end
			end
			mse_pkg::B_SETUP: state_nxt = mse_pkg::B_RD;
			mse_pkg::B_RD:    state_nxt = mse_pkg::B_MRG;
			mse_pkg::B_MRG: begin
				if (run_end) begin
					state_nxt = (pass_end && sort_done) ? mse_pkg::B_EMIT_RD
					                                    : mse_pkg::B_SETUP;
				end else begin
					state_nxt = mse_pkg::B_RD;
				end
			end
			mse_pkg::B_EMIT_RD: state_nxt = mse_pkg::B_EMIT_OUT;
			mse_pkg::B_EMIT_OUT: begin
				if (out_free) begin
					state_nxt = emit_last ? mse_pkg::B_LOAD : mse_pkg::B_EMIT_RD;
				end
			end
			default: state_nxt = mse_pkg::B_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mse_pkg::B_LOAD;
			wcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (q_pop) begin
				if (q_item.last) begin
					wcnt_q <= '0;
				end else if (q_item.keep) begin
					wcnt_q <= wcnt_q + 1'b1;
				end
			end
			if ((state_q == mse_pkg::B_EMIT_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			mse_pkg::B_LOAD: begin
				if (q_pop && q_item.last) begin
					n_q   <= n_new;
					ovf_q <= q_item.ovf;
					sel_q <= 1'b0;
					w_q   <= XW'(1);
					lo_q  <= '0;
					e_q   <= '0;
				end
			end
			mse_pkg::B_SETUP: begin
				mid_q <= mid_nxt;
				hi_q  <= hi_nxt;
				i_q   <= lo_q;
				j_q   <= mid_nxt;
				k_q   <= lo_q;
			end
			mse_pkg::B_MRG: begin
				if (take_x) begin
					i_q <= i_q + 1'b1;
				end else begin
					j_q <= j_q + 1'b1;
				end
				k_q <= k_inc;
				if (run_end) begin
					if (pass_end) begin
						w_q   <= w2;
						sel_q <= ~sel_q;
						lo_q  <= '0;
					end else begin
						lo_q <= hi_q;
					end
				end
			end
			mse_pkg::B_EMIT_OUT: begin
				if (out_free) begin
					e_q         <= e_q + 1'b1;
					res_q.value <= x;
					res_q.last  <= emit_last;
					res_q.ovf   <= ovf_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/merge_sort_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// merge_sort_engine: stable ascending sort of signed 32-bit lists
// Loads one element per request, sorts on the request marked last by a
// bottom-up merge between two stores, and streams the sorted list back out.
// ----------------------------------------------------------------------------
//
//  channel   | dir | tdata                 | tlast           | tuser
//  ----------+-----+-----------------------+-----------------+-----------
//  s_axis    | in  | element_value [31:0]  | is_last         | -
//  m_axis    | out | sorted_value  [31:0]  | is_last_out     | overflow
//
//  Loading writes each kept request into store A as it leaves the intake queue.
//  Sorting a list of n elements takes ceil(log2 n) passes; each pass reads
//  every element from a store, then compares and writes it, with a setup
//  step per pair of runs. Emitting reads each result, then registers it.
//  The intake queue (four requests) keeps taking requests while the back
//  part sorts or waits on m_axis_tready; a full queue drops s_axis_tready.
//  Reset is asynchronous; the stores need no clearing pass.
//  Up to DEPTH elements per list are kept; later ones are dropped and flag
//  overflow on every result of that list.
//
module merge_sort_engine #(
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// request side
	input  wire logic                s_axis_tvalid,
	output logic                     s_axis_tready,
	input  wire logic signed [31:0]  s_axis_tdata,   // [31:0] element_value
	input  wire logic                s_axis_tlast,   // is_last
	// result side
	output logic                     m_axis_tvalid,
	input  wire logic                m_axis_tready,
	output logic signed [31:0]       m_axis_tdata,   // [31:0] sorted_value
	output logic                     m_axis_tlast,   // is_last_out
	output logic                     m_axis_tuser    // [0] overflow
);

	logic                 push;
	logic                 q_full;
	logic                 q_empty;
	logic                 q_pop;
	mse_pkg::mse_item_t   push_item;
	mse_pkg::mse_item_t   q_item;
	mse_pkg::mse_result_t res;

	// classify each request: keep or drop, running overflow flag
	mse_front #(
		.DEPTH (DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_value  (s_axis_tdata),
		.in_last   (s_axis_tlast),
		.q_full    (q_full),
		.in_ready  (s_axis_tready),
		.push      (push),
		.push_item (push_item)
	);

	// hold classified requests while the sorter is busy
	mse_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (q_pop),
		.pop_item  (q_item),
		.full      (q_full),
		.empty     (q_empty)
	);

	// load, merge and emit
	mse_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_res   (res)
	);

	assign m_axis_tdata = res.value;
	assign m_axis_tlast = res.last;
	assign m_axis_tuser = res.ovf;

endmodule
`default_nettype wire

// ===== rtl/mse_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mse_checker: port-level checks of the merge sort engine
// Watches the result channel for stalls, reset quiet and per-list overflow.
// ----------------------------------------------------------------------------
module mse_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               m_axis_tvalid,
	input wire logic               m_axis_tready,
	input wire logic signed [31:0] m_axis_tdata,
	input wire logic               m_axis_tlast,
	input wire logic               m_axis_tuser
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
			&& $stable(m_axis_tuser))
		else $error("result changed while stalled");

	// nothing to show right after reset
	a_reset_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		$past(!arst_n) |-> !m_axis_tvalid)
		else $error("result valid right after reset");

	// overflow is the same on every result of one list
	a_ovf_steady: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast ##1 m_axis_tvalid |->
			m_axis_tuser == $past(m_axis_tuser))
		else $error("overflow changed within a list");

endmodule

bind merge_sort_engine mse_checker u_mse_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
